### hw/rtl/rgb_to_hsv_pixel_defines.svh
// Assertion macros shared by the RGB to HSV pixel checker.
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// Checks a property at every rising edge while the block is out of reset.
`define RHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property at every rising edge, reset included.
`define RHP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/rhp_pkg.sv
// Types and constants of the RGB to HSV pixel converter.
`default_nettype none

package rhp_pkg;

  // Sector that holds the largest channel; red wins ties, then green.
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  // Pipeline shape: input stage, numerator stage, divider stages, output stage.
  localparam int unsigned SAT_QW     = 17;
  localparam int unsigned HUE_QW     = 12;
  localparam int unsigned SAT_RW     = 24;
  localparam int unsigned HUE_RW     = 21;
  localparam int unsigned DIV_STAGES = SAT_QW;
  localparam int unsigned NUM_STAGES = DIV_STAGES + 3;

  // Twice 60 degrees in hue units, so one extra divisor bit gives rounding.
  localparam logic [HUE_RW-1:0] HUE_SIXTY_X2   = 21'd7680;
  localparam logic [15:0]       HUE_BASE_GREEN = 16'd7680;
  localparam logic [15:0]       HUE_BASE_BLUE  = 16'd15360;
  localparam logic [15:0]       HUE_FULL_TURN  = 16'd23040;

  // Result of the first stage: extremes, sector and hue numerator parts.
  typedef struct packed {
    logic [7:0] mx;
    logic [7:0] delta;
    sector_e    sector;
    logic       neg;
    logic [7:0] mag;
  } prep_t;

  // State of both restoring dividers as it moves down the pipeline.
  typedef struct packed {
    logic [SAT_RW-1:0] sat_rem;
    logic [7:0]        sat_div;
    logic [SAT_QW-1:0] sat_quo;
    logic [HUE_RW-1:0] hue_rem;
    logic [8:0]        hue_div;
    logic [HUE_QW-1:0] hue_quo;
    logic              zero;
    logic              neg;
    sector_e           sector;
    logic [7:0]        mx;
  } div_t;

endpackage

`default_nettype wire

### hw/rtl/rgb_to_hsv_pixel.sv
// Top level of the pipelined RGB to HSV pixel converter.
//
// Usage: a pixel request (red_i, green_i, blue_i) is taken at a rising edge
// where valid_i is high and stall_o is low. Results leave on hue_o,
// saturation_o and value_o and are taken where valid_o is high and stall_i is
// low. Hue is signed degrees times 64, saturation is times 65536.
// The pipeline has 20 register stages and takes one pixel per clock while the
// receiver does not stall; the depth is set by the two restoring dividers,
// which resolve one quotient bit per stage over 17 stages. When the receiver
// stalls, the output stage holds and stages behind it keep filling until they
// meet a full stage, so stall_o rises only when all 20 stages hold pixels.
// Reset clears every valid bit and the wrap register. cfg_we_i writes the wrap
// bit; the user must use it only while idle, as the block does not check this.
`default_nettype none

module rgb_to_hsv_pixel
  import rhp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [15:0]      hue_o,
  output logic [16:0]      saturation_o,
  output logic [7:0]       value_o
);

  localparam int unsigned LAST = NUM_STAGES - 1;

  logic                  wrap_q;
  logic [LAST:0]         valid_q;
  logic [LAST:0]         valid_d;
  logic [LAST:0]         adv;
  logic [LAST:0]         valid_up;

  prep_t                 prep_d;
  prep_t                 prep_q;
  div_t                  num_d;
  div_t                  dq_q [DIV_STAGES+1];

  logic [7:0]            mx_rg;
  logic [7:0]            mn_rg;
  logic [7:0]            mx;
  logic [7:0]            mn;
  logic [8:0]            diff;
  sector_e               sector;

  logic [15:0]           hue_mag;
  logic [15:0]           hue_sgn;
  logic [15:0]           hue_base;
  logic [15:0]           hue_wrap;
  logic [15:0]           hue_d;
  logic [16:0]           sat_d;
  logic [15:0]           hue_q;
  logic [16:0]           sat_q;
  logic [7:0]            value_q;

  // Wrap register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= 1'b0;
    end else if (cfg_we_i) begin
      wrap_q <= cfg_wdata_i;
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  assign adv[LAST] = !valid_q[LAST] || !stall_i;
  for (genvar k = 0; k < LAST; k++) begin : g_adv
    assign adv[k] = !valid_q[k] || adv[k+1];
  end

  assign valid_up = {valid_q[LAST-1:0], valid_i};
  assign valid_d  = (adv & valid_up) | (~adv & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign stall_o = !adv[0];

  // Stage 0: extremes, sector and signed channel difference.
  always_comb begin
    mx_rg = (red_i >= green_i) ? red_i : green_i;
    mn_rg = (red_i <= green_i) ? red_i : green_i;
    mx    = (blue_i > mx_rg) ? blue_i : mx_rg;
    mn    = (blue_i < mn_rg) ? blue_i : mn_rg;
    priority if (red_i == mx) begin
      sector = SECT_RED;
    end else if (green_i == mx) begin
      sector = SECT_GREEN;
    end else begin
      sector = SECT_BLUE;
    end
    unique case (sector)
      SECT_RED:   diff = {1'b0, green_i} - {1'b0, blue_i};
      SECT_GREEN: diff = {1'b0, blue_i} - {1'b0, red_i};
      SECT_BLUE:  diff = {1'b0, red_i} - {1'b0, green_i};
      default:    diff = '0;
    endcase
    prep_d.mx     = mx;
    prep_d.delta  = mx - mn;
    prep_d.sector = sector;
    prep_d.neg    = diff[8];
    prep_d.mag    = diff[8] ? 8'(-diff) : diff[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      prep_q <= prep_d;
    end
  end

  // Stage 1: numerators and divisors, with half the divisor added for rounding.
  always_comb begin
    num_d.sat_rem = {prep_q.delta, 16'b0} + {17'b0, prep_q.mx[7:1]};
    num_d.sat_div = prep_q.mx;
    num_d.sat_quo = '0;
    num_d.hue_rem = HUE_RW'(prep_q.mag) * HUE_SIXTY_X2 + HUE_RW'(prep_q.delta);
    num_d.hue_div = {prep_q.delta, 1'b0};
    num_d.hue_quo = '0;
    num_d.zero    = (prep_q.delta == 8'd0);
    num_d.neg     = prep_q.neg;
    num_d.sector  = prep_q.sector;
    num_d.mx      = prep_q.mx;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      dq_q[0] <= num_d;
    end
  end

  // Divider stages: each resolves one saturation quotient bit; the last HUE_QW also resolve one hue bit.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int unsigned B = SAT_QW - 1 - k;
    div_t              nxt;
    logic [SAT_RW-1:0] sat_sh;

    assign sat_sh = SAT_RW'(dq_q[k].sat_div) << B;

    if (B < HUE_QW) begin : g_hue
      logic [HUE_RW-1:0] hue_sh;
      assign hue_sh = HUE_RW'(dq_q[k].hue_div) << B;
      always_comb begin
        nxt = dq_q[k];
        if (dq_q[k].sat_rem >= sat_sh) begin
          nxt.sat_rem    = dq_q[k].sat_rem - sat_sh;
          nxt.sat_quo[B] = 1'b1;
        end
        if (dq_q[k].hue_rem >= hue_sh) begin
          nxt.hue_rem    = dq_q[k].hue_rem - hue_sh;
          nxt.hue_quo[B] = 1'b1;
        end
      end
    end else begin : g_sat_only
      always_comb begin
        nxt = dq_q[k];
        if (dq_q[k].sat_rem >= sat_sh) begin
          nxt.sat_rem    = dq_q[k].sat_rem - sat_sh;
          nxt.sat_quo[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k+2]) begin
        dq_q[k+1] <= nxt;
      end
    end
  end

  // Output stage: sign, sector base, optional wrap and the flat-pixel case.
  always_comb begin
    hue_mag = {4'b0, dq_q[DIV_STAGES].hue_quo};
    hue_sgn = dq_q[DIV_STAGES].neg ? -hue_mag : hue_mag;
    unique case (dq_q[DIV_STAGES].sector)
      SECT_RED:   hue_base = '0;
      SECT_GREEN: hue_base = HUE_BASE_GREEN;
      SECT_BLUE:  hue_base = HUE_BASE_BLUE;
      default:    hue_base = '0;
    endcase
    hue_wrap = (dq_q[DIV_STAGES].sector == SECT_RED && dq_q[DIV_STAGES].neg && wrap_q)
             ? HUE_FULL_TURN : '0;
    if (dq_q[DIV_STAGES].zero) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = hue_base + hue_sgn + hue_wrap;
      sat_d = dq_q[DIV_STAGES].sat_quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[LAST]) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      value_q <= dq_q[DIV_STAGES].mx;
    end
  end

  assign valid_o      = valid_q[LAST];
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign value_o      = value_q;

endmodule

`default_nettype wire

### hw/rtl/rhp_checker.sv
// Port-level checker for the RGB to HSV pixel converter, bound to the top level.
`default_nettype none
`include "rgb_to_hsv_pixel_defines.svh"

module rhp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_o,
  input wire logic        stall_i,
  input wire logic [15:0] hue_o,
  input wire logic [16:0] saturation_o,
  input wire logic [7:0]  value_o
);

  // A held result keeps its fields.
  `RHP_ASSERT(a_out_hold, valid_o && stall_i |=> valid_o && $stable(hue_o) && $stable(saturation_o) && $stable(value_o), "stalled result changed")

  // No result is offered while reset is applied.
  `RHP_ASSERT_RST(a_rst_quiet, !rst_ni |-> !valid_o, "result valid during reset")

  // Saturation never exceeds one.
  `RHP_ASSERT(a_sat_range, valid_o |-> saturation_o <= 17'd65536, "saturation above one")

  // A black pixel has no hue and no saturation.
  `RHP_ASSERT(a_black, valid_o && value_o == 8'd0 |-> hue_o == 16'd0 && saturation_o == 17'd0, "black pixel not flat")

  // Zero saturation only for a grey pixel, which has zero hue.
  `RHP_ASSERT(a_grey, valid_o && saturation_o == 17'd0 |-> hue_o == 16'd0, "grey pixel has hue")

endmodule

bind rgb_to_hsv_pixel rhp_checker u_rhp_checker (.*);

`default_nettype wire

### dv/rgb_to_hsv_pixel_test.sv
// Self-checking testbench for the pipelined RGB to HSV pixel converter.
`timescale 1ns / 100ps

module rgb_to_hsv_pixel_test
  import rhp_pkg::*;
();

  // Fixed-point scale of the conversion: hue in degrees times 64, saturation times 65536.
  localparam int SECTOR_SPAN  = 3840;
  localparam int GREEN_BASE   = 7680;
  localparam int BLUE_BASE    = 15360;
  localparam int FULL_TURN    = 23040;
  localparam int SAT_FULL     = 65536;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 30;

  // One converted pixel as it leaves the block.
  typedef struct packed {
    logic [15:0] hue;
    logic [16:0] saturation;
    logic [7:0]  value;
  } pixel_hsv_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        valid_i;
  logic        stall_o;
  logic [7:0]  red_i;
  logic [7:0]  green_i;
  logic [7:0]  blue_i;
  logic        valid_o;
  logic        stall_i;
  logic [15:0] hue_o;
  logic [16:0] saturation_o;
  logic [7:0]  value_o;

  // Converted pixels still owed by the block, oldest first.
  pixel_hsv_t hsv_expected_q[$];

  logic wrap_setting   = 1'b0;
  int   fail_count     = 0;
  int   idle_cycles    = 0;
  int   stall_pct      = 0;
  int   holdoff_cycles = 0;
  int   gap_max        = 0;
  int   burst_left     = 0;

  rgb_to_hsv_pixel dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .value_o      (value_o)
  );

  always #1 clk_i = ~clk_i;

  // Computes hue, saturation and value of one pixel under the given wrap bit.
  function automatic pixel_hsv_t predict_hsv(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic wrap);
    int rr, gg, bb, mx, mn, delta, num, mag, quo, hue, sat;
    sector_e sector;
    pixel_hsv_t res;
    rr = int'(r);
    gg = int'(g);
    bb = int'(b);
    mx = rr;
    mn = rr;
    if (gg > mx) mx = gg;
    if (bb > mx) mx = bb;
    if (gg < mn) mn = gg;
    if (bb < mn) mn = bb;
    delta = mx - mn;
    hue = 0;
    sat = 0;
    if (mx != 0 && delta != 0) begin
      sat = (delta * SAT_FULL + mx / 2) / mx;
      // Red wins a tie for the maximum, then green.
      if (rr == mx) begin
        sector = SECT_RED;
        num = gg - bb;
      end else if (gg == mx) begin
        sector = SECT_GREEN;
        num = bb - rr;
      end else begin
        sector = SECT_BLUE;
        num = rr - gg;
      end
      // Offset within the sector, rounded to nearest with ties away from zero.
      mag = (num < 0) ? -num : num;
      quo = (mag * 2 * SECTOR_SPAN + delta) / (2 * delta);
      case (sector)
        SECT_RED:   hue = 0;
        SECT_GREEN: hue = GREEN_BASE;
        default:    hue = BLUE_BASE;
      endcase
      hue += (num < 0) ? -quo : quo;
      if (sector == SECT_RED && hue < 0 && wrap) hue += FULL_TURN;
    end
    res.hue        = hue[15:0];
    res.saturation = sat[16:0];
    res.value      = mx[7:0];
    return res;
  endfunction

  // Records the result that an accepted pixel request is owed.
  function automatic void owe_result(input pixel_hsv_t p);
    hsv_expected_q.insert(hsv_expected_q.size(), p);
  endfunction

  // Picks a random pixel, weighted toward greys, ties, extremes and small deltas.
  function automatic void pick_pixel(output logic [7:0] r, output logic [7:0] g,
                                     output logic [7:0] b);
    int kind;
    logic [7:0] m;
    kind = $urandom_range(99);
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    if (kind < 55) begin
      return;
    end else if (kind < 63) begin
      g = r;
      b = r;
    end else if (kind < 70) begin
      r = 8'($urandom_range(3));
      g = 8'($urandom_range(3));
      b = 8'($urandom_range(3));
    end else if (kind < 80) begin
      // Two channels share the maximum.
      m = 8'($urandom_range(255, 1));
      case ($urandom_range(2))
        0: begin r = m; g = m; b = 8'($urandom_range(m)); end
        1: begin g = m; b = m; r = 8'($urandom_range(m)); end
        default: begin r = m; b = m; g = 8'($urandom_range(m)); end
      endcase
    end else if (kind < 90) begin
      r = ($urandom_range(2) == 0) ? 8'h00 : ($urandom_range(1) ? 8'hFF : 8'($urandom));
      g = ($urandom_range(2) == 0) ? 8'h00 : ($urandom_range(1) ? 8'hFF : 8'($urandom));
      b = ($urandom_range(2) == 0) ? 8'h00 : ($urandom_range(1) ? 8'hFF : 8'($urandom));
    end else begin
      // Nearly grey: tiny deltas stress the rounding.
      m = 8'($urandom);
      r = m;
      g = m ^ 8'($urandom_range(3));
      b = m ^ 8'($urandom_range(3));
    end
  endfunction

  // Offers one pixel request, waits for it to be taken, then maybe pauses.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    valid_i <= 1'b1;
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    owe_result(predict_hsv(r, g, b, wrap_setting));
    if (gap_max > 0) begin
      burst_left--;
      if (burst_left <= 0) begin
        valid_i <= 1'b0;
        red_i   <= 8'($urandom);
        green_i <= 8'($urandom);
        blue_i  <= 8'($urandom);
        repeat ($urandom_range(gap_max, 1)) @(posedge clk_i);
        burst_left = $urandom_range(24, 1);
      end
    end
  endtask

  // Stops offering and waits until every owed result has come out.
  task automatic drain_requests();
    valid_i <= 1'b0;
    while (hsv_expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes the wrap register once the pipeline is empty.
  task automatic set_wrap(input logic w);
    drain_requests();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    wrap_setting = w;
  endtask

  task automatic run_random_items(input int count);
    logic [7:0] r, g, b;
    repeat (count) begin
      pick_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  // Black, greys, pure primaries, ties for the maximum and the hue extremes.
  task automatic test_directed_pixels();
    stall_pct = 0;
    gap_max   = 0;
    set_wrap(1'b0);
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd1,   8'd0);
    send_pixel(8'd200, 8'd100, 8'd150);
    send_pixel(8'd10,  8'd0,   8'd255);
    send_pixel(8'd2,   8'd1,   8'd0);
  endtask

  // Negative red-sector hues with the wrap on; other sectors must not move.
  task automatic test_wrapped_red_sector();
    set_wrap(1'b1);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0);
  endtask

  task automatic test_random_no_wrap();
    set_wrap(1'b0);
    stall_pct = 25;
    gap_max   = 6;
    run_random_items(120);
  endtask

  // Full rate on both sides.
  task automatic test_back_to_back();
    stall_pct = 0;
    gap_max   = 0;
    run_random_items(60);
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall its input.
  task automatic test_output_hold_off();
    set_wrap(1'b1);
    stall_pct      = 0;
    gap_max        = 0;
    holdoff_cycles = 160;
    run_random_items(60);
  endtask

  task automatic test_random_wrap();
    set_wrap(1'b1);
    stall_pct = 40;
    gap_max   = 10;
    run_random_items(120);
  endtask

  task automatic test_random_heavy_stall();
    set_wrap(1'b0);
    stall_pct = 75;
    gap_max   = 3;
    run_random_items(100);
  endtask

  // Receiver stall pattern: runs of random length, stalled with the chosen odds.
  initial begin
    int run_left;
    run_left = 0;
    stall_i  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_cycles > 0) begin
        stall_i <= 1'b1;
        repeat (holdoff_cycles) @(posedge clk_i);
        holdoff_cycles = 0;
        run_left       = 0;
        stall_i <= 1'b0;
      end else if (run_left <= 0) begin
        stall_i <= ($urandom_range(99) < stall_pct);
        run_left = $urandom_range(6, 1);
      end else begin
        run_left--;
      end
    end
  end

  // Compares each accepted result with the oldest owed one.
  always @(posedge clk_i) begin
    pixel_hsv_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (hsv_expected_q.size() == 0) begin
        $error("result with no pixel request pending: hue %0d saturation %0d value %0d",
               $signed(hue_o), saturation_o, value_o);
        fail_count++;
      end else begin
        want = hsv_expected_q.pop_front();
        if (hue_o !== want.hue) begin
          $error("hue mismatch: expected %0d, actual %0d", $signed(want.hue), $signed(hue_o));
          fail_count++;
        end
        if (saturation_o !== want.saturation) begin
          $error("saturation mismatch: expected %0d, actual %0d", want.saturation,
                 saturation_o);
          fail_count++;
        end
        if (value_o !== want.value) begin
          $error("value mismatch: expected %0d, actual %0d", want.value, value_o);
          fail_count++;
        end
      end
    end
  end

  // Ends the run if neither side moves a request for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset, then the tests in turn, then the final verdict.
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    valid_i     = 1'b0;
    red_i       = 8'd0;
    green_i     = 8'd0;
    blue_i      = 8'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_pixels();
    test_wrapped_red_sector();
    test_random_no_wrap();
    test_back_to_back();
    test_output_hold_off();
    test_random_wrap();
    test_random_heavy_stall();
    drain_requests();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
